FILE: rtl/core/vecs_pkg.sv
// Shared types and constants of the voxel erosion core/skin block.
// No dependencies; every other file of the block but vecs_dline imports this package.
package vecs_pkg;

  // default capacities, handed to the top-level parameters
  localparam int DEF_MAX_DIM_X = 64;
  localparam int DEF_MAX_DIM_Y = 64;
  localparam int DEF_MAX_DIM_Z = 64;
  localparam int DEF_MAX_DEPTH = 8;

  // fixed field widths
  localparam int DIM_W      = 7;
  localparam int DEPTH_W    = 4;
  localparam int IDX_W      = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // register reset values
  localparam logic [DIM_W-1:0]   RST_DIM   = 7'd64;
  localparam logic [DEPTH_W-1:0] RST_DEPTH = 4'd1;

  // cycles spent refreshing the derived geometry after reset or a register write
  localparam logic [2:0] SETTLE_CYCLES = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_X      = 3'd0,
    REG_DIM_Y      = 3'd1,
    REG_DIM_Z      = 3'd2,
    REG_CORE_DEPTH = 3'd3,
    REG_SKIN_DEPTH = 3'd4
  } vecs_reg_e;

  // per-word control handed from the sequencer to the datapath
  typedef struct packed {
    logic push;  // word enters the line buffers
    logic emit;  // word produces an output voxel
    logic last;  // output voxel closes the grid
    logic vox;   // grid bit entering the cascade
  } vecs_step_t;

endpackage

FILE: rtl/core/vecs_if.sv
// Channel interfaces of the voxel erosion block: input words, result words
// and register writes. Depends on vecs_pkg for field widths.
interface vecs_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic voxel;
  modport source (output valid, output kind, output voxel, input ready);
  modport sink   (input valid, input kind, input voxel, output ready);
endinterface

interface vecs_out_if import vecs_pkg::*;;
  logic             valid;
  logic             ready;
  logic             valid_res;
  logic             core_bit;
  logic             skin_bit;
  logic [IDX_W-1:0] voxel_index;
  logic             last;
  modport source (output valid, output valid_res, output core_bit, output skin_bit,
                  output voxel_index, output last, input ready);
  modport sink   (input valid, input valid_res, input core_bit, input skin_bit,
                  input voxel_index, input last, output ready);
endinterface

interface vecs_cfg_if import vecs_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/vecs_dline.sv
// Variable-length delay line over a circular RAM with registered read.
// Depends on nothing; used by the erosion window buffers.
module vecs_dline #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             push_i,
  input  logic [LW-1:0]    len_i,
  input  logic [WIDTH-1:0] din_i,
  output logic [WIDTH-1:0] dout_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [PW-1:0]    ptr_q, ptr_d;

  always_comb begin
    ptr_d = ptr_q;
    if (clr_i) begin
      ptr_d = '0;
    end else if (push_i) begin
      if (LW'(ptr_q) + LW'(1) >= len_i) begin
        ptr_d = '0;
      end else begin
        ptr_d = ptr_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  // read-first: the tap holds the word written len pushes ago
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      rd_q       <= mem[ptr_q];
      mem[ptr_q] <= din_i;
    end
  end

  assign dout_o = rd_q;

endmodule

FILE: rtl/core/vecs_ctrl.sv
// Register file, derived geometry and raster counters of the erosion block.
// Depends on vecs_pkg (register codes, step struct).
module vecs_ctrl import vecs_pkg::*; #(
  parameter int MAX_DIM_X = DEF_MAX_DIM_X,
  parameter int MAX_DIM_Y = DEF_MAX_DIM_Y,
  parameter int MAX_DIM_Z = DEF_MAX_DIM_Z,
  parameter int MAX_DEPTH = DEF_MAX_DEPTH,
  localparam int XW   = $clog2(MAX_DIM_X + 1),
  localparam int YW   = $clog2(MAX_DIM_Y + 1),
  localparam int ZW   = $clog2(MAX_DIM_Z + 1),
  localparam int IW   = $clog2(MAX_DIM_X + MAX_DEPTH + 1),
  localparam int DW   = $clog2(MAX_DEPTH + 1),
  localparam int YZW  = $clog2(MAX_DIM_Y * MAX_DIM_Z + 1),
  localparam int ODEP = MAX_DEPTH * MAX_DIM_Y * MAX_DIM_Z,
  localparam int LAGW = $clog2(ODEP + 1),
  localparam int OPW  = (ODEP > 1) ? $clog2(ODEP) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_acc_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  acc_i,
  input  logic                  kind_i,
  input  logic                  voxel_i,
  output logic                  hold_o,
  output vecs_step_t            step_o,
  output logic [MAX_DEPTH-1:0]  mask_o,
  output logic [DW-1:0]         cd_o,
  output logic [DW-1:0]         sd_o,
  output logic [DW-1:0]         dd_o,
  output logic [LAGW-1:0]       lag_o,
  output logic [OPW-1:0]        cptr0_o,
  output logic [OPW-1:0]        sptr0_o,
  output logic [YZW-1:0]        l1_o,
  output logic [ZW-1:0]         l2_o
);

  logic [DIM_W-1:0]   dim_x_q, dim_y_q, dim_z_q;
  logic [DEPTH_W-1:0] core_q, skin_q;
  logic [2:0]         settle_q;

  logic [XW-1:0]   nx_q;
  logic [YW-1:0]   ny_q;
  logic [ZW-1:0]   nz_q;
  logic [DW-1:0]   cd_q, sd_q, dd_q;
  logic [YZW-1:0]  yz_q, l1_q;
  logic [ZW-1:0]   l2_q;
  logic [LAGW-1:0] lag_q, cdyz_q, sdyz_q;
  logic [OPW-1:0]  cptr0_q, sptr0_q;

  logic [IW-1:0] iq_q, iq_d;
  logic [YW-1:0] jq_q, jq_d;
  logic [ZW-1:0] kq_q, kq_d;

  logic       real_w, jk_int;
  vecs_step_t step;
  logic [DW-1:0] cd_c, sd_c, cd_n, sd_n;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_x_q  <= RST_DIM;
      dim_y_q  <= RST_DIM;
      dim_z_q  <= RST_DIM;
      core_q   <= RST_DEPTH;
      skin_q   <= RST_DEPTH;
      settle_q <= SETTLE_CYCLES;
    end else begin
      if (cfg_acc_i) begin
        settle_q <= SETTLE_CYCLES;
        case (vecs_reg_e'(cfg_idx_i))
          REG_DIM_X:      dim_x_q <= cfg_data_i;
          REG_DIM_Y:      dim_y_q <= cfg_data_i;
          REG_DIM_Z:      dim_z_q <= cfg_data_i;
          REG_CORE_DEPTH: core_q  <= cfg_data_i[DEPTH_W-1:0];
          REG_SKIN_DEPTH: skin_q  <= cfg_data_i[DEPTH_W-1:0];
          default: ;
        endcase
      end else if (settle_q != '0) begin
        settle_q <= settle_q - 3'd1;
      end
    end
  end

  assign cd_c = DW'((int'(core_q) > MAX_DEPTH) ? MAX_DEPTH : int'(core_q));
  assign sd_c = DW'((int'(skin_q) > MAX_DEPTH) ? MAX_DEPTH : int'(skin_q));

  // a depth past the plane count clears everything; cap it so the lag stays within the grid
  assign cd_n = (int'(cd_c) > int'(nx_q)) ? DW'(nx_q) : cd_c;
  assign sd_n = (int'(sd_c) > int'(nx_q)) ? DW'(nx_q) : sd_c;

  // derived geometry, one multiply per register level
  always_ff @(posedge clk_i) begin
    nx_q <= XW'((dim_x_q == '0) ? 1 : ((int'(dim_x_q) > MAX_DIM_X) ? MAX_DIM_X : int'(dim_x_q)));
    ny_q <= YW'((dim_y_q == '0) ? 1 : ((int'(dim_y_q) > MAX_DIM_Y) ? MAX_DIM_Y : int'(dim_y_q)));
    nz_q <= ZW'((dim_z_q == '0) ? 1 : ((int'(dim_z_q) > MAX_DIM_Z) ? MAX_DIM_Z : int'(dim_z_q)));
    cd_q <= cd_n;
    sd_q <= sd_n;
    dd_q <= (cd_n > sd_n) ? cd_n : sd_n;

    yz_q <= YZW'(ny_q) * YZW'(nz_q);
    l2_q <= (int'(nz_q) < 3) ? ZW'(1) : nz_q - ZW'(2);

    lag_q  <= LAGW'(dd_q) * LAGW'(yz_q);
    cdyz_q <= LAGW'(cd_q) * LAGW'(yz_q);
    sdyz_q <= LAGW'(sd_q) * LAGW'(yz_q);
    l1_q   <= (int'(ny_q) < 3 || int'(nz_q) < 3) ? YZW'(1)
                                                  : yz_q - YZW'(nz_q) - YZW'(1);

    cptr0_q <= (cdyz_q == '0) ? '0 : OPW'(lag_q - cdyz_q);
    sptr0_q <= (sdyz_q == '0) ? '0 : OPW'(lag_q - sdyz_q);
  end

  // step decode: plane index iq runs past the grid while flushes drain the lag
  always_comb begin
    real_w    = iq_q < IW'(nx_q);
    step.push = acc_i && (real_w || kind_i);
    step.emit = step.push && (iq_q >= IW'(dd_q));
    step.last = step.emit && (iq_q + IW'(1) == IW'(nx_q) + IW'(dd_q))
                && (jq_q + YW'(1) == ny_q) && (kq_q + ZW'(1) == nz_q);
    step.vox  = real_w && !kind_i && voxel_i;
    jk_int    = (jq_q != '0) && (jq_q + YW'(1) < ny_q)
                && (kq_q != '0) && (kq_q + ZW'(1) < nz_q);
    for (int d = 1; d <= MAX_DEPTH; d++) begin
      mask_o[d-1] = real_w && jk_int && (iq_q >= IW'(d + 1))
                    && (iq_q + IW'(1) < IW'(nx_q) + IW'(d));
    end
  end

  always_comb begin
    iq_d = iq_q;
    jq_d = jq_q;
    kq_d = kq_q;
    if (cfg_acc_i || step.last) begin
      iq_d = '0;
      jq_d = '0;
      kq_d = '0;
    end else if (step.push) begin
      if (kq_q + ZW'(1) == nz_q) begin
        kq_d = '0;
        if (jq_q + YW'(1) == ny_q) begin
          jq_d = '0;
          iq_d = iq_q + IW'(1);
        end else begin
          jq_d = jq_q + YW'(1);
        end
      end else begin
        kq_d = kq_q + ZW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iq_q <= '0;
      jq_q <= '0;
      kq_q <= '0;
    end else begin
      iq_q <= iq_d;
      jq_q <= jq_d;
      kq_q <= kq_d;
    end
  end

  assign hold_o  = settle_q != '0;
  assign step_o  = step;
  assign cd_o    = cd_q;
  assign sd_o    = sd_q;
  assign dd_o    = dd_q;
  assign lag_o   = lag_q;
  assign cptr0_o = cptr0_q;
  assign sptr0_o = sptr0_q;
  assign l1_o    = l1_q;
  assign l2_o    = l2_q;

endmodule

FILE: rtl/core/vecs_win.sv
// Plane/row line buffers and the six-neighbour erosion cascade.
// Depends on vecs_pkg and vecs_dline.
module vecs_win import vecs_pkg::*; #(
  parameter int MAX_DIM_Y = DEF_MAX_DIM_Y,
  parameter int MAX_DIM_Z = DEF_MAX_DIM_Z,
  parameter int MAX_DEPTH = DEF_MAX_DEPTH,
  localparam int ZW  = $clog2(MAX_DIM_Z + 1),
  localparam int YZW = $clog2(MAX_DIM_Y * MAX_DIM_Z + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 hold_i,
  input  vecs_step_t           step_i,
  input  logic [MAX_DEPTH-1:0] mask_i,
  input  logic [YZW-1:0]       l1_i,
  input  logic [ZW-1:0]        l2_i,
  output logic [MAX_DEPTH:0]   lev_o
);

  // taps relative to the stencil centre p: newest word is p+yz
  logic [MAX_DEPTH-1:0] t_fwd_row, t_fwd_one, t_ctr_q, t_bck_one_q, t_bck_row, t_bck_pln;
  logic [MAX_DEPTH:0]   lev;

  always_comb begin
    lev[0] = step_i.vox;
    for (int d = 1; d <= MAX_DEPTH; d++) begin
      lev[d] = mask_i[d-1] & lev[d-1] & t_fwd_row[d-1] & t_fwd_one[d-1] & t_ctr_q[d-1]
               & t_bck_one_q[d-1] & t_bck_row[d-1] & t_bck_pln[d-1];
    end
  end

  vecs_dline #(.WIDTH(MAX_DEPTH), .DEPTH(MAX_DIM_Y * MAX_DIM_Z)) u_fwd_pln (
    .clk_i, .rst_ni, .clr_i(hold_i), .push_i(step_i.push), .len_i(l1_i),
    .din_i(lev[MAX_DEPTH-1:0]), .dout_o(t_fwd_row)
  );

  vecs_dline #(.WIDTH(MAX_DEPTH), .DEPTH(MAX_DIM_Z)) u_fwd_row (
    .clk_i, .rst_ni, .clr_i(hold_i), .push_i(step_i.push), .len_i(l2_i),
    .din_i(t_fwd_row), .dout_o(t_fwd_one)
  );

  always_ff @(posedge clk_i) begin
    if (step_i.push) begin
      t_ctr_q     <= t_fwd_one;
      t_bck_one_q <= t_ctr_q;
    end
  end

  vecs_dline #(.WIDTH(MAX_DEPTH), .DEPTH(MAX_DIM_Z)) u_bck_row (
    .clk_i, .rst_ni, .clr_i(hold_i), .push_i(step_i.push), .len_i(l2_i),
    .din_i(t_bck_one_q), .dout_o(t_bck_row)
  );

  vecs_dline #(.WIDTH(MAX_DEPTH), .DEPTH(MAX_DIM_Y * MAX_DIM_Z)) u_bck_pln (
    .clk_i, .rst_ni, .clr_i(hold_i), .push_i(step_i.push), .len_i(l1_i),
    .din_i(t_bck_row), .dout_o(t_bck_pln)
  );

  assign lev_o = lev;

endmodule

FILE: rtl/core/vecs_align.sv
// Output alignment RAMs, voxel index counter and the result register.
// Depends on vecs_pkg (step struct, index width).
module vecs_align import vecs_pkg::*; #(
  parameter int MAX_DIM_Y = DEF_MAX_DIM_Y,
  parameter int MAX_DIM_Z = DEF_MAX_DIM_Z,
  parameter int MAX_DEPTH = DEF_MAX_DEPTH,
  localparam int DW   = $clog2(MAX_DEPTH + 1),
  localparam int ODEP = MAX_DEPTH * MAX_DIM_Y * MAX_DIM_Z,
  localparam int LAGW = $clog2(ODEP + 1),
  localparam int OPW  = (ODEP > 1) ? $clog2(ODEP) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               hold_i,
  input  logic               acc_i,
  input  vecs_step_t         step_i,
  input  logic [MAX_DEPTH:0] lev_i,
  input  logic [DW-1:0]      cd_i,
  input  logic [DW-1:0]      sd_i,
  input  logic [DW-1:0]      dd_i,
  input  logic [LAGW-1:0]    lag_i,
  input  logic [OPW-1:0]     cptr0_i,
  input  logic [OPW-1:0]     sptr0_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               valid_res_o,
  output logic               core_bit_o,
  output logic               skin_bit_o,
  output logic [IDX_W-1:0]   voxel_index_o,
  output logic               last_o
);

  logic gmem [ODEP];
  logic cmem [ODEP];
  logic smem [ODEP];

  logic [OPW-1:0]   rp_q, cp_q, sp_q;
  logic [IDX_W-1:0] opos_q;
  logic             ov_q, vres_q, last_q, g_q, c_q, s_q;
  logic [IDX_W-1:0] idx_q;

  function automatic logic [OPW-1:0] wrap_inc(logic [OPW-1:0] p, logic [LAGW-1:0] len);
    if (LAGW'(p) + LAGW'(1) >= len) begin
      return '0;
    end
    return p + OPW'(1);
  endfunction

  // pointers: read at the output position, write each level at its own position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q   <= '0;
      cp_q   <= '0;
      sp_q   <= '0;
      opos_q <= '0;
    end else if (hold_i) begin
      rp_q   <= '0;
      cp_q   <= cptr0_i;
      sp_q   <= sptr0_i;
      opos_q <= '0;
    end else begin
      if (step_i.push) begin
        rp_q <= wrap_inc(rp_q, lag_i);
        cp_q <= wrap_inc(cp_q, lag_i);
        sp_q <= wrap_inc(sp_q, lag_i);
      end
      if (step_i.emit) begin
        opos_q <= step_i.last ? '0 : opos_q + IDX_W'(1);
      end
    end
  end

  // bypass a level that is already at the output position
  always_ff @(posedge clk_i) begin
    if (step_i.push) begin
      gmem[rp_q] <= lev_i[0];
      cmem[cp_q] <= lev_i[cd_i];
      smem[sp_q] <= lev_i[sd_i];
      g_q <= (dd_i == '0)   ? lev_i[0]     : gmem[rp_q];
      c_q <= (cd_i == dd_i) ? lev_i[cd_i]  : cmem[rp_q];
      s_q <= (sd_i == dd_i) ? lev_i[sd_i]  : smem[rp_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      vres_q <= step_i.emit;
      last_q <= step_i.last;
      idx_q  <= step_i.emit ? opos_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (acc_i) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  assign out_valid_o   = ov_q;
  assign valid_res_o   = vres_q;
  assign core_bit_o    = vres_q & c_q;
  assign skin_bit_o    = vres_q & g_q & ~s_q;
  assign voxel_index_o = idx_q;
  assign last_o        = last_q;

endmodule

FILE: rtl/core/voxel_erosion_core_skin.sv
// Top level of the streaming 3D six-neighbour erosion block (core and skin).
// Depends on vecs_pkg, vecs_if, vecs_ctrl, vecs_win, vecs_align.
//
//   port   | dir | words carried
//   -------+-----+-----------------------------------------------
//   cfg_i  | in  | register writes: index, data (always ready)
//   in_i   | in  | one voxel or flush word: kind, voxel
//   out_o  | out | one result word per input word
//
// Each input word is accepted on a handshake and its result word is registered
// the cycle after; a word per cycle is sustained while the output is not stalled,
// set by the combinational erosion cascade between the line-buffer RAM taps and
// the result register. After reset or a register write the input stays not
// ready while the plane size and lag are recomputed.
// A stalled result holds in place; one new word can still enter as it leaves.
module voxel_erosion_core_skin import vecs_pkg::*; #(
  parameter int MAX_DIM_X = DEF_MAX_DIM_X,
  parameter int MAX_DIM_Y = DEF_MAX_DIM_Y,
  parameter int MAX_DIM_Z = DEF_MAX_DIM_Z,
  parameter int MAX_DEPTH = DEF_MAX_DEPTH,
  localparam int ZW   = $clog2(MAX_DIM_Z + 1),
  localparam int DW   = $clog2(MAX_DEPTH + 1),
  localparam int YZW  = $clog2(MAX_DIM_Y * MAX_DIM_Z + 1),
  localparam int ODEP = MAX_DEPTH * MAX_DIM_Y * MAX_DIM_Z,
  localparam int LAGW = $clog2(ODEP + 1),
  localparam int OPW  = (ODEP > 1) ? $clog2(ODEP) : 1
) (
  input  logic clk_i,
  input  logic rst_ni,
  vecs_cfg_if.sink   cfg_i,
  vecs_in_if.sink    in_i,
  vecs_out_if.source out_o
);

  logic                 hold, in_acc, cfg_acc;
  vecs_step_t           step;
  logic [MAX_DEPTH-1:0] mask;
  logic [MAX_DEPTH:0]   lev;
  logic [DW-1:0]        cd, sd, dd;
  logic [LAGW-1:0]      lag;
  logic [OPW-1:0]       cptr0, sptr0;
  logic [YZW-1:0]       l1;
  logic [ZW-1:0]        l2;
  logic                 out_valid;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign in_i.ready  = !hold && (!out_valid || out_o.ready);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid;

  vecs_ctrl #(
    .MAX_DIM_X(MAX_DIM_X), .MAX_DIM_Y(MAX_DIM_Y),
    .MAX_DIM_Z(MAX_DIM_Z), .MAX_DEPTH(MAX_DEPTH)
  ) u_ctrl (
    .clk_i, .rst_ni,
    .cfg_acc_i(cfg_acc), .cfg_idx_i(cfg_i.index), .cfg_data_i(cfg_i.data),
    .acc_i(in_acc), .kind_i(in_i.kind), .voxel_i(in_i.voxel),
    .hold_o(hold), .step_o(step), .mask_o(mask),
    .cd_o(cd), .sd_o(sd), .dd_o(dd), .lag_o(lag),
    .cptr0_o(cptr0), .sptr0_o(sptr0), .l1_o(l1), .l2_o(l2)
  );

  vecs_win #(
    .MAX_DIM_Y(MAX_DIM_Y), .MAX_DIM_Z(MAX_DIM_Z), .MAX_DEPTH(MAX_DEPTH)
  ) u_win (
    .clk_i, .rst_ni, .hold_i(hold), .step_i(step), .mask_i(mask),
    .l1_i(l1), .l2_i(l2), .lev_o(lev)
  );

  vecs_align #(
    .MAX_DIM_Y(MAX_DIM_Y), .MAX_DIM_Z(MAX_DIM_Z), .MAX_DEPTH(MAX_DEPTH)
  ) u_align (
    .clk_i, .rst_ni, .hold_i(hold), .acc_i(in_acc), .step_i(step), .lev_i(lev),
    .cd_i(cd), .sd_i(sd), .dd_i(dd), .lag_i(lag), .cptr0_i(cptr0), .sptr0_i(sptr0),
    .out_ready_i(out_o.ready), .out_valid_o(out_valid),
    .valid_res_o(out_o.valid_res), .core_bit_o(out_o.core_bit),
    .skin_bit_o(out_o.skin_bit), .voxel_index_o(out_o.voxel_index),
    .last_o(out_o.last)
  );

  // every accepted word yields a result word on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_o.valid)
    else $error("accepted word produced no result");

  // a register write blocks input while geometry is refreshed
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc |=> !in_i.ready)
    else $error("input ready right after a register write");

  // end of grid only on a carrying result
  a_last_carries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> out_o.valid_res)
    else $error("last flag on an empty result");

  // a flagged grid end carries the output position counter as its index
  a_index_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && step.emit && step.last) |=> (out_o.voxel_index == $past(u_align.opos_q)))
    else $error("index mismatch on grid end");

endmodule
